/* sv/least_squares_plane_fit_core_macros.svh */
// assertion macros for the plane fit core
`ifndef LEAST_SQUARES_PLANE_FIT_CORE_MACROS_SVH
`define LEAST_SQUARES_PLANE_FIT_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define LSPF_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define LSPF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LSPF_ASSERT_IMPL(label, ante, cons, msg)
`define LSPF_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* sv/lspf_pkg.sv */
`timescale 1ns / 1ps
package lspf_pkg;

	localparam int COORD_BITS = 12;
	localparam int VALUE_BITS = 16;
	localparam int SX_W = 24;
	localparam int SZ_W = 28;
	localparam int SXX_W = 36;
	localparam int SXZ_W = 40;
	localparam int USED_W = 13;
	// wide enough for the offset numerator after scaling
	localparam int WIDE_W = 160;
	localparam int DCNT_W = $clog2(WIDE_W + 1);
	localparam int PC_W = 5;
	localparam logic [PC_W-1:0] SING_PC = 5'd25;

	typedef enum logic [1:0] {FIT_SOLVED, FIT_SINGULAR, FIT_EMPTY} fit_status_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] sample_x;
		logic [COORD_BITS-1:0] sample_y;
		logic [VALUE_BITS-1:0] sample_value;
		logic                  last_sample;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] slope_x;
		logic signed [31:0] slope_y;
		logic signed [47:0] offset;
		fit_status_t        fit_status;
		logic [USED_W-1:0]  samples_used;
	} result_t;

	typedef enum logic [4:0] {
		OPD_N, OPD_SX, OPD_SY, OPD_SZ, OPD_SXX, OPD_SYY, OPD_SXY, OPD_SXZ, OPD_SYZ,
		OPD_CXX, OPD_CYY, OPD_CXY, OPD_CXZ, OPD_CYZ, OPD_DEN, OPD_NA, OPD_NB,
		OPD_NC, OPD_T
	} opnd_t;

	typedef enum logic [1:0] {UOP_MUL, UOP_CHK, UOP_DIV, UOP_END} uop_kind_t;
	typedef enum logic [1:0] {RES_A, RES_B, RES_C} res_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_CHECK, ST_FETCH, ST_MUL, ST_DIV, ST_DONE
	} state_t;

	typedef struct packed {
		uop_kind_t kind;
		opnd_t     src_a;
		opnd_t     src_b;
		opnd_t     dst;
		logic      sub;
		res_sel_t  res;
		logic      c_shift;
	} uop_t;

	typedef struct packed {
		logic acc_en;
		logic begin_fit;
		logic set_empty;
		logic set_singular;
		logic mul_load;
		logic mul_wb;
		logic div_load;
		logic div_wb;
		logic clear_acc;
		uop_t uop;
	} cmd_t;

	typedef struct packed {
		logic n_zero;
		logic den_zero;
		logic mul_done;
		logic div_done;
	} stat_t;

	function automatic uop_t mk_mul(input opnd_t a, input opnd_t b, input opnd_t d,
			input logic s);
		uop_t u;
		u = '{kind: UOP_MUL, src_a: a, src_b: b, dst: d, sub: s, res: RES_A, c_shift: 1'b0};
		return u;
	endfunction

	function automatic uop_t mk_div(input opnd_t a, input opnd_t b, input res_sel_t r,
			input logic c);
		uop_t u;
		u = '{kind: UOP_DIV, src_a: a, src_b: b, dst: OPD_N, sub: 1'b0, res: r, c_shift: c};
		return u;
	endfunction

	function automatic uop_t mk_ctl(input uop_kind_t k);
		uop_t u;
		u = '{kind: k, src_a: OPD_N, src_b: OPD_N, dst: OPD_N, sub: 1'b0, res: RES_A,
			c_shift: 1'b0};
		return u;
	endfunction

	// solve sequence: centred moments, determinant, numerators, quotients
	function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
		uop_t u;
		case (pc)
			5'd0: u = mk_mul(OPD_SXX, OPD_N, OPD_CXX, 1'b0);
			5'd1: u = mk_mul(OPD_SX, OPD_SX, OPD_CXX, 1'b1);
			5'd2: u = mk_mul(OPD_SYY, OPD_N, OPD_CYY, 1'b0);
			5'd3: u = mk_mul(OPD_SY, OPD_SY, OPD_CYY, 1'b1);
			5'd4: u = mk_mul(OPD_SXY, OPD_N, OPD_CXY, 1'b0);
			5'd5: u = mk_mul(OPD_SY, OPD_SX, OPD_CXY, 1'b1);
			5'd6: u = mk_mul(OPD_SXZ, OPD_N, OPD_CXZ, 1'b0);
			5'd7: u = mk_mul(OPD_SZ, OPD_SX, OPD_CXZ, 1'b1);
			5'd8: u = mk_mul(OPD_SYZ, OPD_N, OPD_CYZ, 1'b0);
			5'd9: u = mk_mul(OPD_SZ, OPD_SY, OPD_CYZ, 1'b1);
			5'd10: u = mk_mul(OPD_CXX, OPD_CYY, OPD_DEN, 1'b0);
			5'd11: u = mk_mul(OPD_CXY, OPD_CXY, OPD_DEN, 1'b1);
			5'd12: u = mk_ctl(UOP_CHK);
			5'd13: u = mk_mul(OPD_CXZ, OPD_CYY, OPD_NA, 1'b0);
			5'd14: u = mk_mul(OPD_CYZ, OPD_CXY, OPD_NA, 1'b1);
			5'd15: u = mk_mul(OPD_CYZ, OPD_CXX, OPD_NB, 1'b0);
			5'd16: u = mk_mul(OPD_CXZ, OPD_CXY, OPD_NB, 1'b1);
			5'd17: u = mk_mul(OPD_DEN, OPD_SZ, OPD_NC, 1'b0);
			5'd18: u = mk_mul(OPD_NA, OPD_SX, OPD_NC, 1'b1);
			5'd19: u = mk_mul(OPD_NB, OPD_SY, OPD_NC, 1'b1);
			5'd20: u = mk_mul(OPD_DEN, OPD_N, OPD_T, 1'b0);
			5'd21: u = mk_div(OPD_NA, OPD_DEN, RES_A, 1'b0);
			5'd22: u = mk_div(OPD_NB, OPD_DEN, RES_B, 1'b0);
			5'd23: u = mk_div(OPD_NC, OPD_T, RES_C, 1'b1);
			5'd24: u = mk_ctl(UOP_END);
			// singular system: offset is the mean
			5'd25: u = mk_div(OPD_SZ, OPD_N, RES_C, 1'b1);
			default: u = mk_ctl(UOP_END);
		endcase
		return u;
	endfunction

	function automatic logic [31:0] sat32(input logic [WIDE_W-1:0] v);
		logic [WIDE_W-32:0] hi;
		hi = v[WIDE_W-1:31];
		if ((&hi) || !(|hi))
			return v[31:0];
		return v[WIDE_W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
	endfunction

	function automatic logic [47:0] sat48(input logic [WIDE_W-1:0] v);
		logic [WIDE_W-48:0] hi;
		hi = v[WIDE_W-1:47];
		if ((&hi) || !(|hi))
			return v[47:0];
		return v[WIDE_W-1] ? 48'h8000_0000_0000 : 48'h7fff_ffff_ffff;
	endfunction

endpackage

/* sv/lspf_ctrl.sv */
`timescale 1ns / 1ps
module lspf_ctrl
	import lspf_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  logic  last_sample,
	input  stat_t stat,
	output cmd_t  cmd,
	output logic  busy,
	output logic  result_valid
);

	state_t state_q, state_d;
	logic [PC_W-1:0] pc_q, pc_d;
	uop_t uop;

	assign uop = uop_rom(pc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= '0;
		end else begin
			state_q <= state_d;
			pc_q <= pc_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pc_d = pc_q;
		cmd = '0;
		cmd.uop = uop;
		busy = 1'b1;
		result_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.acc_en = 1'b1;
					if (last_sample)
						state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (stat.n_zero) begin
					cmd.set_empty = 1'b1;
					state_d = ST_DONE;
				end else begin
					cmd.begin_fit = 1'b1;
					pc_d = '0;
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				case (uop.kind)
					UOP_MUL: begin
						cmd.mul_load = 1'b1;
						state_d = ST_MUL;
					end
					UOP_CHK: begin
						if (stat.den_zero) begin
							cmd.set_singular = 1'b1;
							pc_d = SING_PC;
						end else begin
							pc_d = pc_q + PC_W'(1);
						end
					end
					UOP_DIV: begin
						cmd.div_load = 1'b1;
						state_d = ST_DIV;
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_MUL: begin
				if (stat.mul_done) begin
					cmd.mul_wb = 1'b1;
					pc_d = pc_q + PC_W'(1);
					state_d = ST_FETCH;
				end
			end
			ST_DIV: begin
				if (stat.div_done) begin
					cmd.div_wb = 1'b1;
					pc_d = pc_q + PC_W'(1);
					state_d = ST_FETCH;
				end
			end
			ST_DONE: begin
				result_valid = 1'b1;
				cmd.clear_acc = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

/* sv/lspf_dpath.sv */
`timescale 1ns / 1ps
module lspf_dpath
	import lspf_pkg::*;
#(
	parameter int MAX_SAMPLES = 4096
) (
	input  logic    clk,
	input  logic    arst_n,
	input  sample_t sample,
	input  cmd_t    cmd,
	output stat_t   stat,
	output result_t result
);

	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int W = WIDE_W;

	logic [CNT_W-1:0] count_q;
	logic [SX_W-1:0]  sum_x_q, sum_y_q;
	logic [SZ_W-1:0]  sum_z_q;
	logic [SXX_W-1:0] sum_xx_q, sum_yy_q, sum_xy_q;
	logic [SXZ_W-1:0] sum_xz_q, sum_yz_q;

	logic [W-1:0] cxx_q, cyy_q, cxy_q, cxz_q, cyz_q, den_q, na_q, nb_q, nc_q, t_q;
	logic [W-1:0] ma_q, mb_q, mp_q;
	logic [W-1:0] quo_q, rem_q, den2_q;
	logic         neg_q;
	logic [DCNT_W-1:0] dcnt_q;
	result_t res_q;

	logic [2*COORD_BITS-1:0]          pxx, pyy, pxy;
	logic [COORD_BITS+VALUE_BITS-1:0] pxz, pyz;
	logic [W-1:0] opa, opb, cur, wb_val;
	logic [W-1:0] absn, absd, numer, quo_s;
	logic [W:0]   r2, den2x;
	logic [4:0]   sh;

	assign pxx = sample.sample_x * sample.sample_x;
	assign pyy = sample.sample_y * sample.sample_y;
	assign pxy = sample.sample_x * sample.sample_y;
	assign pxz = sample.sample_x * sample.sample_value;
	assign pyz = sample.sample_y * sample.sample_value;

	function automatic logic [W-1:0] pick(input opnd_t s, input logic [W-1:0] n,
			input logic [W-1:0] sx, input logic [W-1:0] sy, input logic [W-1:0] sz,
			input logic [W-1:0] sxx, input logic [W-1:0] syy, input logic [W-1:0] sxy,
			input logic [W-1:0] sxz, input logic [W-1:0] syz, input logic [W-1:0] cxx,
			input logic [W-1:0] cyy, input logic [W-1:0] cxy, input logic [W-1:0] cxz,
			input logic [W-1:0] cyz, input logic [W-1:0] den, input logic [W-1:0] na,
			input logic [W-1:0] nb, input logic [W-1:0] nc, input logic [W-1:0] t);
		logic [W-1:0] v;
		case (s)
			OPD_N:   v = n;
			OPD_SX:  v = sx;
			OPD_SY:  v = sy;
			OPD_SZ:  v = sz;
			OPD_SXX: v = sxx;
			OPD_SYY: v = syy;
			OPD_SXY: v = sxy;
			OPD_SXZ: v = sxz;
			OPD_SYZ: v = syz;
			OPD_CXX: v = cxx;
			OPD_CYY: v = cyy;
			OPD_CXY: v = cxy;
			OPD_CXZ: v = cxz;
			OPD_CYZ: v = cyz;
			OPD_DEN: v = den;
			OPD_NA:  v = na;
			OPD_NB:  v = nb;
			OPD_NC:  v = nc;
			OPD_T:   v = t;
			default: v = '0;
		endcase
		return v;
	endfunction

	always_comb begin
		opa = pick(cmd.uop.src_a, W'(count_q), W'(sum_x_q), W'(sum_y_q), W'(sum_z_q),
			W'(sum_xx_q), W'(sum_yy_q), W'(sum_xy_q), W'(sum_xz_q), W'(sum_yz_q),
			cxx_q, cyy_q, cxy_q, cxz_q, cyz_q, den_q, na_q, nb_q, nc_q, t_q);
		opb = pick(cmd.uop.src_b, W'(count_q), W'(sum_x_q), W'(sum_y_q), W'(sum_z_q),
			W'(sum_xx_q), W'(sum_yy_q), W'(sum_xy_q), W'(sum_xz_q), W'(sum_yz_q),
			cxx_q, cyy_q, cxy_q, cxz_q, cyz_q, den_q, na_q, nb_q, nc_q, t_q);
		cur = pick(cmd.uop.dst, W'(count_q), W'(sum_x_q), W'(sum_y_q), W'(sum_z_q),
			W'(sum_xx_q), W'(sum_yy_q), W'(sum_xy_q), W'(sum_xz_q), W'(sum_yz_q),
			cxx_q, cyy_q, cxy_q, cxz_q, cyz_q, den_q, na_q, nb_q, nc_q, t_q);
		wb_val = cmd.uop.sub ? cur - mp_q : mp_q;
	end

	// rounded quotient: (2|n| + |d|) / (2|d|), scaling folded into the shift
	always_comb begin
		absn = opa[W-1] ? -opa : opa;
		absd = opb[W-1] ? -opb : opb;
		sh = cmd.uop.c_shift ? 5'd17 : 5'd15;
		numer = (absn << sh) + absd;
		r2 = {rem_q, quo_q[W-1]};
		den2x = {1'b0, den2_q};
		quo_s = neg_q ? -quo_q : quo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_z_q <= '0;
			sum_xx_q <= '0;
			sum_yy_q <= '0;
			sum_xy_q <= '0;
			sum_xz_q <= '0;
			sum_yz_q <= '0;
			mb_q <= '0;
			dcnt_q <= '0;
		end else begin
			if (cmd.clear_acc) begin
				count_q <= '0;
				sum_x_q <= '0;
				sum_y_q <= '0;
				sum_z_q <= '0;
				sum_xx_q <= '0;
				sum_yy_q <= '0;
				sum_xy_q <= '0;
				sum_xz_q <= '0;
				sum_yz_q <= '0;
			end else if (cmd.acc_en && count_q < CNT_W'(MAX_SAMPLES)) begin
				count_q <= count_q + CNT_W'(1);
				sum_x_q <= sum_x_q + SX_W'(sample.sample_x);
				sum_y_q <= sum_y_q + SX_W'(sample.sample_y);
				sum_z_q <= sum_z_q + SZ_W'(sample.sample_value);
				sum_xx_q <= sum_xx_q + SXX_W'(pxx);
				sum_yy_q <= sum_yy_q + SXX_W'(pyy);
				sum_xy_q <= sum_xy_q + SXX_W'(pxy);
				sum_xz_q <= sum_xz_q + SXZ_W'(pxz);
				sum_yz_q <= sum_yz_q + SXZ_W'(pyz);
			end
			if (cmd.mul_load)
				mb_q <= opb;
			else if (mb_q != '0)
				mb_q <= mb_q >> 1;
			if (cmd.div_load)
				dcnt_q <= DCNT_W'(W);
			else if (dcnt_q != '0)
				dcnt_q <= dcnt_q - DCNT_W'(1);
		end
	end

	// shift-add multiplier, product modulo 2^W
	always_ff @(posedge clk) begin
		if (cmd.mul_load) begin
			ma_q <= opa;
			mp_q <= '0;
		end else if (mb_q != '0) begin
			if (mb_q[0])
				mp_q <= mp_q + ma_q;
			ma_q <= ma_q << 1;
		end
	end

	// restoring divider, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			quo_q <= numer;
			rem_q <= '0;
			den2_q <= absd << 1;
			neg_q <= opa[W-1] ^ opb[W-1];
		end else if (dcnt_q != '0) begin
			if (r2 >= den2x) begin
				rem_q <= W'(r2 - den2x);
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= r2[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_wb) begin
			case (cmd.uop.dst)
				OPD_CXX: cxx_q <= wb_val;
				OPD_CYY: cyy_q <= wb_val;
				OPD_CXY: cxy_q <= wb_val;
				OPD_CXZ: cxz_q <= wb_val;
				OPD_CYZ: cyz_q <= wb_val;
				OPD_DEN: den_q <= wb_val;
				OPD_NA:  na_q <= wb_val;
				OPD_NB:  nb_q <= wb_val;
				OPD_NC:  nc_q <= wb_val;
				OPD_T:   t_q <= wb_val;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.set_empty || cmd.begin_fit) begin
			res_q.slope_x <= '0;
			res_q.slope_y <= '0;
			res_q.offset <= '0;
			res_q.fit_status <= cmd.set_empty ? FIT_EMPTY : FIT_SOLVED;
			res_q.samples_used <= USED_W'(count_q);
		end else if (cmd.set_singular) begin
			res_q.fit_status <= FIT_SINGULAR;
		end else if (cmd.div_wb) begin
			case (cmd.uop.res)
				RES_A:   res_q.slope_x <= sat32(quo_s);
				RES_B:   res_q.slope_y <= sat32(quo_s);
				default: res_q.offset <= sat48(quo_s);
			endcase
		end
	end

	assign stat.n_zero = (count_q == '0);
	assign stat.den_zero = (den_q == '0);
	assign stat.mul_done = (mb_q == '0);
	assign stat.div_done = (dcnt_q == '0);
	assign result = res_q;

endmodule

/* sv/least_squares_plane_fit_core.sv */
// Least-squares plane fit z = a*x + b*y + c over a set of samples. A sample is taken
// at each clock edge where start is high and busy is low, so samples stream in at one
// per cycle; samples past MAX_SAMPLES in a set are dropped but their last flag still
// counts. The beat flagged last_sample starts the solve, during which busy stays high:
// about twenty shift-add multiplies on a 160 bit datapath, each stepping through the
// multiplier operand bit by bit and ending early when that operand is a small sum,
// then up to three restoring divisions. The result is shown for exactly one cycle
// with result_valid and cannot be held off, so the receiver must take it in that
// cycle.
`timescale 1ns / 1ps
`include "least_squares_plane_fit_core_macros.svh"
module least_squares_plane_fit_core
	import lspf_pkg::*;
#(
	parameter int MAX_SAMPLES = 4096
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  sample_t sample,
	output logic    result_valid,
	output result_t result
);

	cmd_t  cmd;
	stat_t stat;

	lspf_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.last_sample  (sample.last_sample),
		.stat         (stat),
		.cmd          (cmd),
		.busy         (busy),
		.result_valid (result_valid)
	);

	lspf_dpath #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.cmd    (cmd),
		.stat   (stat),
		.result (result)
	);

	`LSPF_ASSERT_NEXT(a_strobe_single, result_valid, !result_valid, "result strobe longer than one cycle")
	`LSPF_ASSERT_IMPL(a_strobe_busy, result_valid, busy, "result given while idle")
	`LSPF_ASSERT_NEXT(a_plain_beat_idle, start && !busy && !sample.last_sample, !busy, "busy after a plain sample")
	`LSPF_ASSERT_NEXT(a_last_beat_busy, start && !busy && sample.last_sample, busy, "no solve after last sample")
	`LSPF_ASSERT_IMPL(a_empty_count, result_valid && result.fit_status == FIT_EMPTY, result.samples_used == '0, "empty set with samples")

endmodule
